FILE: hdl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and constants for the bounded deque
// Request kinds, status codes, sizes and slot arithmetic for the circular store.
// ----------------------------------------------------------------------------
package bdq_pkg;

	// Storage sizes. Capacity is a power of two so slot math wraps naturally.
	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	// Request kinds
	typedef enum logic [2:0] {
		K_PUSH_BACK  = 3'd0,
		K_PUSH_FRONT = 3'd1,
		K_POP_FRONT  = 3'd2,
		K_POP_BACK   = 3'd3,
		K_DELETE     = 3'd4,
		K_CONTAINS   = 3'd5
	} kind_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [DATA_WIDTH-1:0] word_t;

	// Store position of a logical position counted from the front
	function automatic idx_t slot_of(input idx_t front, input cnt_t logical);
		return idx_t'(front + logical[IDX_W-1:0]);
	endfunction

endpackage

FILE: hdl/bounded_deque_with_search_delete.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_search_delete: bounded double-ended queue of words
// Push/pop at both ends, delete by value with gap closing, membership test.
// ----------------------------------------------------------------------------
// Usage:
//   A request (kind, value) is taken at a rising edge with start high and
//   busy low. Exactly one result (status, result_value, count) is presented
//   for a single cycle with done high; the receiver cannot hold it off.
//   busy is high from the accept edge of a multi-cycle request until done
//   rises; a new request may be issued during the cycle in which done is high.
// Sequence per request kind:
//   push front/back, unused kinds and any request on an empty deque finish
//   without a RAM read; pop front/back reads the end entry through the RAM;
//   contains / delete read every held entry, one RAM read per entry,
//   pipelined through the registered read port, and then decide;
//   delete from the middle then closes the gap after the hit position,
//   moving one entry per cycle through the same read port.
// Reset clears the front pointer and count; the store is not cleared since
// only data read from occupied entries is ever used. Empty requests report status empty.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_delete (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [31:0] value,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] result_value,
	output logic [4:0]  count
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_POP    = 5'b00010,
		S_SCAN   = 5'b00100,
		S_DECIDE = 5'b01000,
		S_SHIFT  = 5'b10000
	} state_t;

	state_t             state_q;
	bdq_pkg::kind_t     kind_q;
	bdq_pkg::word_t     word_q;
	bdq_pkg::idx_t      front_q;
	bdq_pkg::cnt_t      cnt_q;
	bdq_pkg::cnt_t      ridx_q;
	bdq_pkg::cnt_t      hit_idx_q;
	logic               hit_q;
	logic               back_hit_q;
	logic               vld_s1;
	bdq_pkg::cnt_t      idx_s1;
	logic               done_q;
	bdq_pkg::status_t   status_q;
	logic [31:0]        result_q;

	logic               accept;
	logic               full;
	logic               empty;
	bdq_pkg::cnt_t      last_idx;
	logic               issue;
	logic               match;
	logic               we;
	bdq_pkg::idx_t      waddr;
	bdq_pkg::word_t     wdata;
	bdq_pkg::idx_t      raddr;
	bdq_pkg::word_t     rdata;

	assign busy         = (state_q != S_IDLE);
	assign accept       = start && !busy;
	assign full         = (cnt_q == bdq_pkg::CNT_W'(bdq_pkg::CAPACITY));
	assign empty        = (cnt_q == '0);
	assign last_idx     = cnt_q - 1'b1;
	assign match        = vld_s1 && (rdata == word_q);
	assign done         = done_q;
	assign status       = status_q;
	assign result_value = result_q;
	assign count        = cnt_q;

	// Read address and issue: pops read one end, scan/shift walk ridx_q
	always_comb begin
		raddr = bdq_pkg::slot_of(front_q, ridx_q);
		issue = 1'b0;
		if (state_q == S_IDLE) begin
			raddr = (kind == bdq_pkg::K_POP_BACK) ? bdq_pkg::slot_of(front_q, last_idx)
			                                      : front_q;
			issue = accept && !empty &&
			        (kind == bdq_pkg::K_POP_FRONT || kind == bdq_pkg::K_POP_BACK);
		end else if (state_q == S_SCAN || state_q == S_SHIFT) begin
			issue = (ridx_q < cnt_q);
		end
	end

	// Write port: pushes at either end, shift moves entry k+1 into k.
	// Shift reads run ahead of writes, so no entry is read and written at once.
	always_comb begin
		we    = 1'b0;
		waddr = bdq_pkg::slot_of(front_q, cnt_q);
		wdata = value;
		if (state_q == S_IDLE && accept && !full) begin
			if (kind == bdq_pkg::K_PUSH_BACK) begin
				we = 1'b1;
			end else if (kind == bdq_pkg::K_PUSH_FRONT) begin
				we    = 1'b1;
				waddr = front_q - 1'b1;
			end
		end else if (state_q == S_SHIFT && vld_s1) begin
			we    = 1'b1;
			waddr = bdq_pkg::slot_of(front_q, idx_s1 - 1'b1);
			wdata = rdata;
		end
	end

	bdq_ram #(
		.DEPTH(bdq_pkg::CAPACITY),
		.WIDTH(bdq_pkg::DATA_WIDTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Read pipeline tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			idx_s1 <= '0;
		end else begin
			vld_s1 <= issue;
			idx_s1 <= ridx_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			kind_q     <= bdq_pkg::K_PUSH_BACK;
			word_q     <= '0;
			front_q    <= '0;
			cnt_q      <= '0;
			ridx_q     <= '0;
			hit_idx_q  <= '0;
			hit_q      <= 1'b0;
			back_hit_q <= 1'b0;
			done_q     <= 1'b0;
			status_q   <= bdq_pkg::ST_OK;
			result_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (issue && state_q != S_IDLE) begin
				ridx_q <= ridx_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q     <= bdq_pkg::kind_t'(kind);
						word_q     <= value;
						ridx_q     <= '0;
						hit_q      <= 1'b0;
						back_hit_q <= 1'b0;
						result_q   <= '0;
						case (kind)
							bdq_pkg::K_PUSH_BACK, bdq_pkg::K_PUSH_FRONT: begin
								done_q <= 1'b1;
								if (full) begin
									status_q <= bdq_pkg::ST_FULL;
								end else begin
									status_q <= bdq_pkg::ST_OK;
									cnt_q    <= cnt_q + 1'b1;
									if (kind == bdq_pkg::K_PUSH_FRONT) begin
										front_q <= front_q - 1'b1;
									end
								end
							end
							bdq_pkg::K_POP_FRONT, bdq_pkg::K_POP_BACK,
							bdq_pkg::K_DELETE, bdq_pkg::K_CONTAINS: begin
								if (empty) begin
									done_q   <= 1'b1;
									status_q <= bdq_pkg::ST_EMPTY;
								end else if (kind == bdq_pkg::K_POP_FRONT ||
								             kind == bdq_pkg::K_POP_BACK) begin
									state_q <= S_POP;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								done_q   <= 1'b1;
								status_q <= bdq_pkg::ST_EMPTY;
							end
						endcase
					end
				end

				// Read data of the popped end is back
				S_POP: begin
					done_q   <= 1'b1;
					status_q <= bdq_pkg::ST_OK;
					result_q <= rdata;
					cnt_q    <= last_idx;
					if (kind_q == bdq_pkg::K_POP_FRONT) begin
						front_q <= front_q + 1'b1;
					end
					state_q <= S_IDLE;
				end

				// Compare every held entry; note first hit and a hit at the back
				S_SCAN: begin
					if (match && !hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_s1;
					end
					if (match && idx_s1 == last_idx) begin
						back_hit_q <= 1'b1;
					end
					if (vld_s1 && idx_s1 == last_idx) begin
						state_q <= S_DECIDE;
					end
				end

				// Priority: front, then back, then first middle hit
				S_DECIDE: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					if (!hit_q) begin
						status_q <= bdq_pkg::ST_EMPTY;
					end else if (kind_q == bdq_pkg::K_CONTAINS) begin
						status_q <= bdq_pkg::ST_OK;
					end else begin
						status_q <= bdq_pkg::ST_OK;
						result_q <= word_q;
						if (hit_idx_q == '0) begin
							front_q <= front_q + 1'b1;
							cnt_q   <= last_idx;
						end else if (back_hit_q) begin
							cnt_q <= last_idx;
						end else begin
							// Middle hit: close the gap before reporting
							done_q  <= 1'b0;
							ridx_q  <= hit_idx_q + 1'b1;
							state_q <= S_SHIFT;
						end
					end
				end

				// Move entries after the hit one place toward the front
				S_SHIFT: begin
					if (vld_s1 && idx_s1 == last_idx) begin
						done_q  <= 1'b1;
						cnt_q   <= last_idx;
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bdq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for bounded_deque_with_search_delete
// Drives push, pop, delete-by-value and contains requests through the
// start/busy handshake. It keeps its own copy of the deque and checks each
// done strobe against the oldest predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

	localparam int STALL_LIMIT  = 2000;              // cycles with no request and no result
	localparam int DRAIN_CYCLES = 2 * bdq_pkg::CAPACITY + 8;  // longer than the slowest request
	localparam int RANDOM_REQS  = 1000;
	localparam int QUIET_TAIL   = 100;               // last requests are sent back to back
	localparam int PHASE_LEN    = 40;
	localparam logic [2:0] KIND_SPARE_LO = 3'd6;     // kind codes with no operation
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;

	// Traffic modes for the random part
	localparam int MODE_FILL  = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIXED = 2;

	typedef struct packed {
		logic [2:0]     kind;
		bdq_pkg::word_t value;
	} deque_req_t;

	typedef struct packed {
		bdq_pkg::status_t status;
		bdq_pkg::word_t   taken;
		bdq_pkg::cnt_t    cnt;
	} deque_result_t;

	logic           clk    = 1'b0;
	logic           arst_n = 1'b0;
	logic           start  = 1'b0;
	logic [2:0]     kind   = '0;
	bdq_pkg::word_t value  = '0;
	logic           busy;
	logic           done;
	logic [1:0]     status;
	logic [31:0]    result_value;
	logic [4:0]     count;

	bounded_deque_with_search_delete uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.value        (value),
		.done         (done),
		.status       (status),
		.result_value (result_value),
		.count        (count)
	);

	// Clock and reset
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin : reset_seq
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Shadow deque
	bdq_pkg::word_t dq_store [bdq_pkg::CAPACITY];
	bdq_pkg::idx_t  dq_front = '0;
	bdq_pkg::cnt_t  dq_count = '0;

	deque_req_t     pending_reqs [$];
	deque_result_t  results_due [$];
	bdq_pkg::word_t word_pool [8];

	int n_issued     = 0;
	int n_accepted   = 0;
	int n_checked    = 0;
	int n_errors     = 0;
	int n_full       = 0;
	int n_miss       = 0;
	int n_mid_delete = 0;
	int peak_fill    = 0;
	int quiet_cycles = 0;
	int gap_left     = 0;

	function automatic bdq_pkg::idx_t dq_slot(input int logical);
		return bdq_pkg::idx_t'((int'(dq_front) + logical) % bdq_pkg::CAPACITY);
	endfunction

	// Apply one request to the shadow deque and return what the block should report
	function automatic deque_result_t deque_apply(input logic [2:0] k,
	                                              input bdq_pkg::word_t v);
		deque_result_t r;
		int pos;
		int i;
		r.status = bdq_pkg::ST_EMPTY;
		r.taken  = '0;
		case (k)
			bdq_pkg::K_PUSH_BACK: begin
				if (dq_count >= bdq_pkg::CAPACITY) begin
					r.status = bdq_pkg::ST_FULL;
				end else begin
					dq_store[dq_slot(dq_count)] = v;
					dq_count++;
					r.status = bdq_pkg::ST_OK;
				end
			end
			bdq_pkg::K_PUSH_FRONT: begin
				if (dq_count >= bdq_pkg::CAPACITY) begin
					r.status = bdq_pkg::ST_FULL;
				end else begin
					dq_front = bdq_pkg::idx_t'((int'(dq_front) + bdq_pkg::CAPACITY - 1)
					                           % bdq_pkg::CAPACITY);
					dq_store[dq_front] = v;
					dq_count++;
					r.status = bdq_pkg::ST_OK;
				end
			end
			bdq_pkg::K_POP_FRONT: begin
				if (dq_count != 0) begin
					r.taken  = dq_store[dq_front];
					dq_front = bdq_pkg::idx_t'((int'(dq_front) + 1) % bdq_pkg::CAPACITY);
					dq_count--;
					r.status = bdq_pkg::ST_OK;
				end
			end
			bdq_pkg::K_POP_BACK: begin
				if (dq_count != 0) begin
					r.taken  = dq_store[dq_slot(dq_count - 1)];
					dq_count--;
					r.status = bdq_pkg::ST_OK;
				end
			end
			bdq_pkg::K_DELETE: begin
				if (dq_count != 0) begin
					// front first, then back, then first match in between
					if (dq_store[dq_front] == v) begin
						r.taken  = v;
						dq_front = bdq_pkg::idx_t'((int'(dq_front) + 1) % bdq_pkg::CAPACITY);
						dq_count--;
						r.status = bdq_pkg::ST_OK;
					end else if (dq_store[dq_slot(dq_count - 1)] == v) begin
						r.taken  = v;
						dq_count--;
						r.status = bdq_pkg::ST_OK;
					end else begin
						pos = 1;
						while (pos + 1 < dq_count && dq_store[dq_slot(pos)] != v)
							pos++;
						if (pos + 1 < dq_count) begin
							// close the gap toward the front
							for (i = pos; i + 1 < dq_count; i++)
								dq_store[dq_slot(i)] = dq_store[dq_slot(i + 1)];
							r.taken  = v;
							dq_count--;
							r.status = bdq_pkg::ST_OK;
							n_mid_delete++;
						end
					end
				end
			end
			bdq_pkg::K_CONTAINS: begin
				for (i = 0; i < dq_count; i++)
					if (dq_store[dq_slot(i)] == v)
						r.status = bdq_pkg::ST_OK;
			end
			default: ;
		endcase
		if (r.status == bdq_pkg::ST_FULL)
			n_full++;
		if (r.status == bdq_pkg::ST_EMPTY)
			n_miss++;
		if (dq_count > peak_fill)
			peak_fill = dq_count;
		r.cnt = dq_count;
		return r;
	endfunction

	function automatic void add_req(input logic [2:0] k, input bdq_pkg::word_t v);
		deque_req_t q;
		q.kind  = k;
		q.value = v;
		pending_reqs.push_back(q);
	endfunction

	// Mostly words from a small pool so that deletes and searches hit
	function automatic bdq_pkg::word_t pick_word();
		if ($urandom_range(0, 9) < 6)
			return word_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	function automatic logic [2:0] draw_kind(input int mode);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
		case (mode)
			MODE_FILL: begin
				if (r < 40) return bdq_pkg::K_PUSH_BACK;
				if (r < 65) return bdq_pkg::K_PUSH_FRONT;
				if (r < 72) return bdq_pkg::K_POP_FRONT;
				if (r < 79) return bdq_pkg::K_POP_BACK;
				if (r < 88) return bdq_pkg::K_DELETE;
			end
			MODE_DRAIN: begin
				if (r < 13) return bdq_pkg::K_PUSH_BACK;
				if (r < 23) return bdq_pkg::K_PUSH_FRONT;
				if (r < 45) return bdq_pkg::K_POP_FRONT;
				if (r < 65) return bdq_pkg::K_POP_BACK;
				if (r < 88) return bdq_pkg::K_DELETE;
			end
			default: begin
				if (r < 20) return bdq_pkg::K_PUSH_BACK;
				if (r < 40) return bdq_pkg::K_PUSH_FRONT;
				if (r < 55) return bdq_pkg::K_POP_FRONT;
				if (r < 70) return bdq_pkg::K_POP_BACK;
				if (r < 88) return bdq_pkg::K_DELETE;
			end
		endcase
		return bdq_pkg::K_CONTAINS;
	endfunction

	// Request driver: one request on the bus until it is taken
	always @(negedge clk) begin : driver
		deque_req_t nx;
		if (arst_n && (!start || n_accepted == n_issued)) begin
			if (gap_left == 0 && pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
				gap_left = $urandom_range(1, 14);
			if (gap_left > 0 || pending_reqs.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				// idle: junk on the request fields
				start <= 1'b0;
				kind  <= 3'($urandom_range(0, 7));
				value <= $urandom;
			end else begin
				nx = pending_reqs.pop_front();
				start <= 1'b1;
				kind  <= nx.kind;
				value <= nx.value;
				n_issued++;
			end
		end
	end

	// Result checker and request tracker
	always @(posedge clk) begin : monitor
		deque_result_t due;
		logic moved;
		if (arst_n) begin
			moved = 1'b0;
			if (done === 1'b1) begin
				moved = 1'b1;
				if (results_due.size() == 0) begin
					$error("unexpected result: status %0d result_value %h count %0d",
						status, result_value, count);
					n_errors++;
				end else begin
					due = results_due.pop_front();
					n_checked++;
					if (status !== due.status) begin
						$error("status: expected %0d, got %0d", due.status, status);
						n_errors++;
					end
					if (result_value !== due.taken) begin
						$error("result_value: expected %h, got %h", due.taken, result_value);
						n_errors++;
					end
					if (count !== due.cnt) begin
						$error("count: expected %0d, got %0d", due.cnt, count);
						n_errors++;
					end
				end
			end
			// request taken at this edge
			if (start && busy === 1'b0) begin
				moved = 1'b1;
				results_due.push_back(deque_apply(kind, value));
				n_accepted++;
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
		end
	end

	initial begin : watchdog
		wait (quiet_cycles >= STALL_LIMIT);
		$display("tb_top NOT OK");
		$finish;
	end

	// Stimulus and end of run
	initial begin : stimulus
		int n;
		int mode;
		logic [2:0] k;
		word_pool[0] = 32'h0000_0000;
		word_pool[1] = 32'hFFFF_FFFF;
		word_pool[2] = 32'h8000_0000;
		word_pool[3] = 32'h7FFF_FFFF;
		for (n = 4; n < 8; n++)
			word_pool[n] = $urandom;

		// empty deque: pops, delete and search all miss
		add_req(bdq_pkg::K_POP_FRONT, 32'h0);
		add_req(bdq_pkg::K_POP_BACK, 32'h0);
		add_req(bdq_pkg::K_DELETE, 32'h0);
		add_req(bdq_pkg::K_CONTAINS, 32'h0);
		add_req(KIND_SPARE_LO, 32'h0);
		// single entry removed by delete: deque goes empty again
		add_req(bdq_pkg::K_PUSH_FRONT, 32'h8000_0000);
		add_req(bdq_pkg::K_DELETE, 32'h8000_0000);
		// fill to capacity with wrap of the front pointer
		add_req(bdq_pkg::K_PUSH_FRONT, 32'h8000_0000);
		add_req(bdq_pkg::K_PUSH_BACK, 32'h7FFF_FFFF);
		add_req(bdq_pkg::K_PUSH_BACK, 32'h0000_0000);
		add_req(bdq_pkg::K_PUSH_BACK, 32'hFFFF_FFFF);
		for (n = 1; n <= bdq_pkg::CAPACITY - 4; n++)
			add_req(bdq_pkg::K_PUSH_BACK, 32'h0101_0101 * n);
		// full: both pushes rejected
		add_req(bdq_pkg::K_PUSH_BACK, 32'h1);
		add_req(bdq_pkg::K_PUSH_FRONT, 32'h1);
		// delete from the middle, then from the back
		add_req(bdq_pkg::K_DELETE, 32'h0000_0000);
		add_req(bdq_pkg::K_DELETE, 32'h0101_0101 * (bdq_pkg::CAPACITY - 4));

		// random traffic in fill, drain and mixed phases
		mode = MODE_MIXED;
		for (n = 0; n < RANDOM_REQS; n++) begin
			if (n % PHASE_LEN == 0)
				mode = $urandom_range(MODE_FILL, MODE_MIXED);
			k = draw_kind(mode);
			add_req(k, (k == bdq_pkg::K_POP_FRONT || k == bdq_pkg::K_POP_BACK)
			           ? bdq_pkg::word_t'($urandom) : pick_word());
		end

		wait (arst_n);
		while (pending_reqs.size() != 0 || n_accepted != n_issued)
			@(negedge clk);
		while (results_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Checked %0d results for %0d requests: %0d full rejections, %0d empty/miss.",
			n_checked, n_accepted, n_full, n_miss);
		$display("Middle deletes with gap closing: %0d, deepest fill: %0d of %0d entries.",
			n_mid_delete, peak_fill, bdq_pkg::CAPACITY);
		if (n_errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
